### rtl/lags_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lags_pkg
// Shared types, constants and helpers of the affine-gap local alignment unit.
// ----------------------------------------------------------------------------
package lags_pkg;

	localparam int MAX_QUERY_LEN_DEF = 256;
	localparam int ALPHABET_SIZE_DEF = 24;

	localparam int CODE_W = 5;
	localparam int SCORE_W = 8;
	localparam int H_W = 7;
	localparam int GAP_W = 7;
	localparam int QLEN_W = 9;
	localparam int CFG_IDX_W = 2;

	localparam logic signed [SCORE_W-1:0] SCORE_MAX = 8'sd127;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = -8'sd128;

	typedef enum logic [1:0] {
		CMD_TABLE = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_DB    = 2'd2
	} lags_cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAP_OPEN   = 2'd0,
		REG_GAP_EXTEND = 2'd1,
		REG_QUERY_LEN  = 2'd2
	} lags_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_EMIT
	} lags_state_t;

	// data handed from one cell to the next
	typedef struct packed {
		logic                      tok;
		logic signed [SCORE_W-1:0] f;
		logic [H_W-1:0]            hup;
		logic [H_W-1:0]            diag;
		logic [H_W-1:0]            best;
		logic                      sat;
	} lags_link_t;

	// clamp a 10-bit signed value to the 8-bit signed range
	function automatic logic signed [SCORE_W-1:0] sat8(input logic signed [9:0] v);
		logic signed [SCORE_W-1:0] r;
		if (v > 10'sd127) begin
			r = SCORE_MAX;
		end else if (v < -10'sd128) begin
			r = SCORE_MIN;
		end else begin
			r = v[SCORE_W-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/lags_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lags_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lags_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/lags_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lags_cell
// One query position: holds its H and E, computes when the token arrives and
// hands F, H and the running best to the next cell.
// ----------------------------------------------------------------------------
module lags_cell import lags_pkg::*; #(
	parameter int INDEX = 0,
	parameter int LW = 9
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lags_link_t                link_i,
	output lags_link_t                link_o,
	input  logic signed [SCORE_W-1:0] score,
	input  logic [GAP_W-1:0]          gap_open,
	input  logic [GAP_W-1:0]          gap_extend,
	input  logic [LW-1:0]             eff_len,
	input  logic                      clr,
	output logic                      done
);

	logic [H_W-1:0]            h_q;
	logic signed [SCORE_W-1:0] e_q;
	lags_link_t                link_q;
	logic                      done_q;

	logic signed [SCORE_W-1:0] e_ext, e_opn, e_new;
	logic signed [SCORE_W-1:0] f_ext, f_opn, f_new;
	logic signed [SCORE_W-1:0] h_dg, h_m;
	logic [H_W-1:0]            h_new;
	logic                      is_last;

	assign is_last = (32'(eff_len) == INDEX + 1);

	// affine gap recurrence for this position
	always_comb begin
		e_ext = sat8({{2{e_q[7]}}, e_q} - {3'b000, gap_extend});
		e_opn = sat8({3'b000, h_q} - {3'b000, gap_open});
		e_new = (e_ext > e_opn) ? e_ext : e_opn;
		f_ext = sat8({{2{link_i.f[7]}}, link_i.f} - {3'b000, gap_extend});
		f_opn = sat8({3'b000, link_i.hup} - {3'b000, gap_open});
		f_new = (f_ext > f_opn) ? f_ext : f_opn;
		h_dg = sat8({3'b000, link_i.diag} + {{2{score[7]}}, score});
		h_m = h_dg;
		if (e_new > h_m) begin
			h_m = e_new;
		end
		if (f_new > h_m) begin
			h_m = f_new;
		end
		if (h_m < 8'sd0) begin
			h_m = 8'sd0;
		end
		h_new = h_m[H_W-1:0];
	end

	// column state, cleared after the last residue of a sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= '0;
			e_q <= SCORE_MIN;
		end else if (clr) begin
			h_q <= '0;
			e_q <= SCORE_MIN;
		end else if (link_i.tok) begin
			h_q <= h_new;
			e_q <= e_new;
		end
	end

	// hand-off to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
			done_q <= 1'b0;
		end else begin
			link_q.tok <= link_i.tok && !is_last;
			done_q <= link_i.tok && is_last;
			if (link_i.tok) begin
				link_q.f <= f_new;
				link_q.hup <= h_new;
				link_q.diag <= h_q;
				link_q.best <= (h_new > link_i.best) ? h_new : link_i.best;
				link_q.sat <= link_i.sat || (h_new == H_W'(SCORE_MAX));
			end
		end
	end

	assign link_o = link_q;
	assign done = done_q;

endmodule

### rtl/local_alignment_affine_gap_score_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_alignment_affine_gap_score_unit
// Smith-Waterman score with affine gaps over a chain of query cells.
// ----------------------------------------------------------------------------
// load beats are taken in the idle state and leave it idle; a database beat
// with L cells in use keeps the input busy through the query read, the table
// read, the L cells and the hand-back; with L = 0 no cell runs; a last database
// beat goes on to the emit state, which loads the result register once any earlier result is taken
// reset: registers to 10, 1, 1; H zero, E -128, best and flag cleared;
// table and query RAMs hold nothing until loaded
module local_alignment_affine_gap_score_unit import lags_pkg::*; #(
	parameter int MAX_QUERY_LEN = MAX_QUERY_LEN_DEF,
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              cmd,
	input  logic [CODE_W-1:0]       table_row,
	input  logic [CODE_W-1:0]       table_col,
	input  logic signed [SCORE_W-1:0] table_value,
	input  logic [7:0]              query_pos,
	input  logic [CODE_W-1:0]       residue,
	input  logic                    last_residue,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [H_W-1:0]          best_score,
	output logic                    saturated,
	input  logic                    cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [QLEN_W-1:0]       cfg_wdata
);

	localparam int QAW = (MAX_QUERY_LEN > 1) ? $clog2(MAX_QUERY_LEN) : 1;
	localparam int LW = $clog2(MAX_QUERY_LEN + 1);
	localparam int TDEPTH = ALPHABET_SIZE * ALPHABET_SIZE;
	localparam int TAW = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;

	logic [GAP_W-1:0]  gap_open_q, gap_extend_q;
	logic [QLEN_W-1:0] query_len_q;
	logic [LW-1:0]     eff_len;

	lags_state_t state_q, state_d;
	logic        in_acc, db_acc, capture, clr, out_load;

	logic [CODE_W-1:0] db_q;
	logic              last_q;
	logic [LW-1:0]     idx_q;
	logic              iss;
	logic              iss_s1, first_s1, iss_s2, first_s2, oor_s2;

	logic              tbl_we, qry_we;
	logic [TAW-1:0]    tbl_waddr, tbl_raddr;
	logic [SCORE_W-1:0] tbl_rdata;
	logic [CODE_W-1:0] qry_rdata;
	logic              oor_s1;

	logic signed [SCORE_W-1:0] score;
	logic                      inject;
	lags_link_t                link_in [MAX_QUERY_LEN];
	lags_link_t                link_out [MAX_QUERY_LEN];
	logic [MAX_QUERY_LEN-1:0]  done_vec;
	logic                      done_any;
	logic [H_W-1:0]            red_best;
	logic                      red_sat;

	logic [H_W-1:0] best_q;
	logic           sat_q;
	logic           out_valid_q;
	logic [H_W-1:0] best_score_q;
	logic           saturated_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_open_q <= GAP_W'(10);
			gap_extend_q <= GAP_W'(1);
			query_len_q <= QLEN_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_GAP_OPEN:   gap_open_q <= cfg_wdata[GAP_W-1:0];
				REG_GAP_EXTEND: gap_extend_q <= cfg_wdata[GAP_W-1:0];
				REG_QUERY_LEN:  query_len_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign eff_len = (32'(query_len_q) > MAX_QUERY_LEN) ? LW'(MAX_QUERY_LEN)
	                                                    : LW'(query_len_q);

	// input beat decode
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc = in_valid && in_ready;
	assign db_acc = in_acc && (cmd == CMD_DB);
	assign tbl_we = in_acc && (cmd == CMD_TABLE) && (32'(table_row) < ALPHABET_SIZE)
	                && (32'(table_col) < ALPHABET_SIZE);
	assign qry_we = in_acc && (cmd == CMD_QUERY) && (32'(query_pos) < MAX_QUERY_LEN);
	assign tbl_waddr = TAW'(32'(table_row) * ALPHABET_SIZE + 32'(table_col));

	// substitution table and query residue memories
	lags_ram #(.WIDTH(SCORE_W), .DEPTH(TDEPTH), .AW(TAW)) u_tbl (
		.clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(table_value),
		.raddr(tbl_raddr), .rdata(tbl_rdata)
	);

	lags_ram #(.WIDTH(CODE_W), .DEPTH(MAX_QUERY_LEN), .AW(QAW)) u_qry (
		.clk(clk), .we(qry_we), .waddr(QAW'(query_pos)), .wdata(residue),
		.raddr(idx_q[QAW-1:0]), .rdata(qry_rdata)
	);

	// score fetch: query read, then table read
	assign iss = (state_q == ST_RUN) && (idx_q < eff_len);
	assign oor_s1 = (32'(db_q) >= ALPHABET_SIZE) || (32'(qry_rdata) >= ALPHABET_SIZE);
	assign tbl_raddr = oor_s1 ? '0 : TAW'(32'(db_q) * ALPHABET_SIZE + 32'(qry_rdata));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			iss_s1 <= 1'b0;
			first_s1 <= 1'b0;
			iss_s2 <= 1'b0;
			first_s2 <= 1'b0;
		end else begin
			if (db_acc) begin
				idx_q <= '0;
			end else if (iss) begin
				idx_q <= idx_q + LW'(1);
			end
			iss_s1 <= iss;
			first_s1 <= iss && (idx_q == '0);
			iss_s2 <= iss_s1;
			first_s2 <= iss_s1 && first_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (db_acc) begin
			db_q <= residue;
			last_q <= last_residue;
		end
		oor_s2 <= oor_s1;
	end

	assign score = oor_s2 ? '0 : $signed(tbl_rdata);
	assign inject = iss_s2 && first_s2;

	// cell chain
	for (genvar i = 0; i < MAX_QUERY_LEN; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign link_in[0] = '{tok: inject, f: SCORE_MIN, hup: H_W'(0),
			                      diag: H_W'(0), best: best_q, sat: sat_q};
		end else begin : g_link
			assign link_in[i] = link_out[i-1];
		end
		lags_cell #(.INDEX(i), .LW(LW)) u_cell (
			.clk(clk), .arst_n(arst_n), .link_i(link_in[i]), .link_o(link_out[i]),
			.score(score), .gap_open(gap_open_q), .gap_extend(gap_extend_q),
			.eff_len(eff_len), .clr(clr), .done(done_vec[i])
		);
	end

	// pick up the running best from the cell that ended the column
	always_comb begin
		red_best = '0;
		red_sat = 1'b0;
		for (int i = 0; i < MAX_QUERY_LEN; i++) begin
			if (done_vec[i]) begin
				red_best = red_best | link_out[i].best;
				red_sat = red_sat | link_out[i].sat;
			end
		end
	end
	assign done_any = |done_vec;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		capture = 1'b0;
		clr = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (db_acc) begin
					if (eff_len == '0) begin
						state_d = last_residue ? ST_EMIT : ST_IDLE;
					end else begin
						state_d = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				if (done_any) begin
					capture = 1'b1;
					state_d = last_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					clr = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// running best over the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
			sat_q <= 1'b0;
		end else if (clr) begin
			best_q <= '0;
			sat_q <= 1'b0;
		end else if (capture) begin
			best_q <= red_best;
			sat_q <= red_sat;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			best_score_q <= sat_q ? H_W'(SCORE_MAX) : best_q;
			saturated_q <= sat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign best_score = best_score_q;
	assign saturated = saturated_q;

	// checks
	a_one_done: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(done_vec)) else $error("more than one cell ended the column");

	a_inject_run: assert property (@(posedge clk) disable iff (!arst_n)
		inject |-> (state_q == ST_RUN)) else $error("token injected outside a column");

	a_done_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_any |-> (state_q == ST_RUN)) else $error("column end outside a column");

	a_sat_best: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && saturated_q) |-> (best_score_q == H_W'(SCORE_MAX)))
		else $error("saturated result without top score");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q) else $error("result load lost");

endmodule
